FILE: rtl/core/gbba_pkg.sv
`timescale 1ns / 1ps

package gbba_pkg;

    // Bitmap geometry
    localparam int MAX_BLOCKS = 65536;
    localparam int WORD_W     = 32;
    localparam int WORDS      = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int WADDR_W    = $clog2(WORDS);
    localparam int MAX_GROUPS = 8;
    localparam int GRP_W      = $clog2(MAX_GROUPS);

    // Field widths
    localparam int BLK_W = 16;
    localparam int CNT_W = 17;
    localparam int LO_W  = 20;
    localparam int SUM_W = 20;

    localparam logic [CNT_W-1:0] COUNT_MAX = 17'd65536;
    localparam logic [CNT_W-1:0] BPG_MIN   = 17'd32;
    localparam logic [CNT_W-1:0] BPG_MAX   = 17'd65536;

    // Configuration register indexes
    localparam logic [1:0] REG_BPG     = 2'd0;
    localparam logic [1:0] REG_NGROUPS = 2'd1;
    localparam logic [1:0] REG_TOTAL   = 2'd2;
    localparam logic [1:0] REG_FDB     = 2'd3;

    typedef enum logic [1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_FREE    = 2'd1,
        MODE_INIT    = 2'd2,
        MODE_RESERVE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOFREE = 2'd1,
        ST_RANGE  = 2'd2
    } t_status;

    typedef struct packed {
        logic [16:0] bpg;
        logic [3:0]  ngroups;
        logic [16:0] total_blocks;
        logic        fdb;
    } t_cfg;

    // Classified request as it sits in the queue
    typedef struct packed {
        t_mode             mode;
        logic [BLK_W-1:0]  rel;
        logic              below;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q;

    typedef struct packed {
        logic clearing;
    } t_back_stat;

    // Blocks per group: multiple of 32, clamped to 32..65536
    function automatic logic [CNT_W-1:0] eff_bpg(input logic [16:0] raw);
        logic [CNT_W-1:0] v;
        v = {raw[16:5], 5'b0};
        if (v < BPG_MIN) v = BPG_MIN;
        if (v > BPG_MAX) v = BPG_MAX;
        return v;
    endfunction

    // Groups in use: clamped to 1..MAX_GROUPS
    function automatic logic [3:0] eff_groups(input logic [3:0] raw);
        logic [3:0] v;
        v = raw;
        if (v == 4'd0) v = 4'd1;
        if (v > 4'(MAX_GROUPS)) v = 4'(MAX_GROUPS);
        return v;
    endfunction

    // End (exclusive) of the usable span of a group starting at lo
    function automatic logic [CNT_W-1:0] span_hi(
        input logic [LO_W-1:0]  lo,
        input logic             last,
        input logic [CNT_W-1:0] bpg,
        input logic [16:0]      total_blocks,
        input logic             fdb
    );
        logic [LO_W:0]    base;
        logic [CNT_W-1:0] rem;
        logic [CNT_W-1:0] bits;
        logic [LO_W:0]    hic;
        logic [CNT_W-1:0] lim;
        base = {1'b0, lo} + {{LO_W{1'b0}}, fdb};
        rem  = ({4'b0, total_blocks} > base) ?
               CNT_W'({4'b0, total_blocks} - base) : '0;
        bits = (last && rem < bpg) ? rem : bpg;
        hic  = {1'b0, lo} + {4'b0, bits};
        lim  = COUNT_MAX - {{(CNT_W-1){1'b0}}, fdb};
        return (hic > {4'b0, lim}) ? lim : CNT_W'(hic);
    endfunction

endpackage

FILE: rtl/core/grouped_bitmap_block_allocator.sv
`timescale 1ns / 1ps

// Grouped first-fit block allocator.
// Commands enter on start/busy with i_mode and i_block_number; a command is
// taken at a clock edge where start is high and busy is low. Modes: allocate,
// free, initialize (all usable blocks free) and reserve.
// Each command gives one result: o_done is high for one cycle with
// o_result_block, o_status and o_free_blocks. The receiver cannot stall.
// Geometry (blocks per group, groups in use, total blocks, first data block) is
// set through APB; the user must write it only while idle, unenforced here.
// A two-entry command queue decouples the front from the executor, so
// busy drops whenever the queue has room, except during the reset clear.
// Free/reserve find the target group by repeated subtraction, then read and
// modify one bitmap word. Allocate pops, skips each group with a zero count
// and scans the words of each group searched in the registered-read bitmap
// RAM. Initialize clears the bitmap, then sets each group's free count.
// After reset the 2048-word bitmap is cleared, one word per cycle; busy is
// high during this clear. Counts start at zero until initialize.
module grouped_bitmap_block_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_block_number,
    output logic        o_done,
    output logic [15:0] o_result_block,
    output logic [1:0]  o_status,
    output logic [16:0] o_free_blocks,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    gbba_pkg::t_cfg       r_cfg;
    gbba_pkg::t_q         q;
    gbba_pkg::t_back_stat stat;
    logic                 pop;
    logic                 cfg_wr;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bpg          <= 17'd8192;
            r_cfg.ngroups      <= 4'd8;
            r_cfg.total_blocks <= 17'd65536;
            r_cfg.fdb          <= 1'b1;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                gbba_pkg::REG_BPG:     r_cfg.bpg          <= pwdata[16:0];
                gbba_pkg::REG_NGROUPS: r_cfg.ngroups      <= pwdata[3:0];
                gbba_pkg::REG_TOTAL:   r_cfg.total_blocks <= pwdata[16:0];
                gbba_pkg::REG_FDB:     r_cfg.fdb          <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            gbba_pkg::REG_BPG:     prdata = {15'b0, r_cfg.bpg};
            gbba_pkg::REG_NGROUPS: prdata = {28'b0, r_cfg.ngroups};
            gbba_pkg::REG_TOTAL:   prdata = {15'b0, r_cfg.total_blocks};
            gbba_pkg::REG_FDB:     prdata = {31'b0, r_cfg.fdb};
            default:               prdata = '0;
        endcase
    end

    gbba_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_block_number (i_block_number),
        .i_fdb          (r_cfg.fdb),
        .i_stat         (stat),
        .o_q            (q),
        .i_pop          (pop)
    );

    gbba_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q            (q),
        .o_pop          (pop),
        .o_stat         (stat),
        .o_done         (o_done),
        .o_result_block (o_result_block),
        .o_status       (o_status),
        .o_free_blocks  (o_free_blocks)
    );

endmodule

FILE: rtl/core/gbba_ram.sv
`timescale 1ns / 1ps

module gbba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

FILE: rtl/core/gbba_front.sv
`timescale 1ns / 1ps

module gbba_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              i_mode,
    input  logic [15:0]             i_block_number,
    input  logic                    i_fdb,
    input  gbba_pkg::t_back_stat    i_stat,
    output gbba_pkg::t_q            o_q,
    input  logic                    i_pop
);

    gbba_pkg::t_item r_q [2];
    logic            r_wr;
    logic            r_rd;
    logic [1:0]      r_cnt;
    logic            push;
    logic            pop;
    gbba_pkg::t_item cls;

    // Classify: relative position and below-first-block flag
    always_comb begin
        cls.mode  = gbba_pkg::t_mode'(i_mode);
        cls.below = i_fdb && (i_block_number == 16'd0);
        cls.rel   = i_block_number - {15'b0, i_fdb};
    end

    assign busy = (r_cnt == 2'd2) || i_stat.clearing;
    assign push = start && !busy;
    assign pop  = i_pop && (r_cnt != 2'd0);

    assign o_q.valid = (r_cnt != 2'd0);
    assign o_q.item  = r_q[r_rd];

    // Two-entry queue toward the executor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= cls;
        end
    end

endmodule

FILE: rtl/core/gbba_back.sv
`timescale 1ns / 1ps

module gbba_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  gbba_pkg::t_cfg       i_cfg,
    input  gbba_pkg::t_q         i_q,
    output logic                 o_pop,
    output gbba_pkg::t_back_stat o_stat,
    output logic                 o_done,
    output logic [15:0]          o_result_block,
    output logic [1:0]           o_status,
    output logic [16:0]          o_free_blocks
);

    localparam int AW = gbba_pkg::WADDR_W;
    localparam int CW = gbba_pkg::CNT_W;
    localparam int LW = gbba_pkg::LO_W;
    localparam int GW = gbba_pkg::GRP_W;

    typedef enum logic [10:0] {
        S_CLEAR = 11'b000_0000_0001,
        S_IDLE  = 11'b000_0000_0010,
        S_GCHK  = 11'b000_0000_0100,
        S_GSPAN = 11'b000_0000_1000,
        S_AREAD = 11'b000_0001_0000,
        S_ATEST = 11'b000_0010_0000,
        S_DDIV  = 11'b000_0100_0000,
        S_DSPAN = 11'b000_1000_0000,
        S_DREAD = 11'b001_0000_0000,
        S_DMOD  = 11'b010_0000_0000,
        S_ISPAN = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_iacc, n_iacc;
    logic   r_init, n_init;
    logic [AW-1:0] r_caddr, n_caddr;
    logic [3:0]    r_g, n_g;
    logic [LW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_hi, n_hi;
    logic [AW-1:0] r_w, n_w;
    logic [15:0]   r_rem, n_rem;
    logic [15:0]   r_pos, n_pos;
    gbba_pkg::t_mode r_mode, n_mode;
    logic [gbba_pkg::SUM_W-1:0] r_sum, n_sum;
    logic [CW-1:0] r_total, n_total;
    logic [CW-1:0] r_cnt [gbba_pkg::MAX_GROUPS];
    logic          cnt_we;
    logic [CW-1:0] cnt_val;
    logic          r_out_valid, n_out_valid;
    logic [15:0]   r_out_result, n_out_result;
    logic [1:0]    r_out_status, n_out_status;
    logic [CW-1:0] r_out_free;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;

    logic [CW-1:0] bpg_e;
    logic [3:0]    ng_e;
    logic          last;
    logic [CW-1:0] cur_cnt;

    assign bpg_e   = gbba_pkg::eff_bpg(i_cfg.bpg);
    assign ng_e    = gbba_pkg::eff_groups(i_cfg.ngroups);
    assign last    = (r_g == ng_e - 4'd1);
    assign cur_cnt = r_cnt[r_g[GW-1:0]];

    function automatic logic [CW-1:0] dec_sat(input logic [CW-1:0] c);
        return (c == '0) ? '0 : c - 1'b1;
    endfunction

    function automatic logic [CW-1:0] inc_sat(input logic [CW-1:0] c);
        return (c >= gbba_pkg::COUNT_MAX) ? gbba_pkg::COUNT_MAX : c + 1'b1;
    endfunction

    gbba_ram #(.WIDTH(gbba_pkg::WORD_W), .DEPTH(gbba_pkg::WORDS)) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Executor sequencer
    always_comb begin
        logic [31:0]   vmask;
        logic [31:0]   fbits;
        logic [4:0]    idx;
        logic [31:0]   bmask;
        logic [CW-1:0] c;
        logic [gbba_pkg::SUM_W-1:0] s;
        n_state      = r_state;
        n_iacc       = r_iacc;
        n_init       = r_init;
        n_caddr      = r_caddr;
        n_g          = r_g;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_w          = r_w;
        n_rem        = r_rem;
        n_pos        = r_pos;
        n_mode       = r_mode;
        n_sum        = r_sum;
        n_total      = r_total;
        cnt_we       = 1'b0;
        cnt_val      = cur_cnt;
        n_out_valid  = 1'b0;
        n_out_result = 16'd0;
        n_out_status = gbba_pkg::ST_OK;
        ram_we       = 1'b0;
        ram_waddr    = r_caddr;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = r_w;
        o_pop        = 1'b0;
        vmask        = '1;
        fbits        = '0;
        idx          = '0;
        bmask        = 32'd1 << r_pos[4:0];
        c            = '0;
        s            = '0;

        unique case (r_state)
            // Sweep the bitmap to zero, after reset and for initialize
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_caddr;
                ram_wdata = '0;
                n_caddr   = r_caddr + 1'b1;
                if (r_caddr == '1) begin
                    if (r_init) begin
                        n_state = S_ISPAN;
                        n_g     = 4'd0;
                        n_lo    = '0;
                        n_sum   = '0;
                        n_iacc  = 1'b0;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                if (i_q.valid) begin
                    o_pop  = 1'b1;
                    n_mode = i_q.item.mode;
                    n_g    = 4'd0;
                    n_lo   = '0;
                    n_rem  = i_q.item.rel;
                    n_pos  = i_q.item.rel;
                    case (i_q.item.mode)
                        gbba_pkg::MODE_ALLOC: begin
                            if (r_total == '0) begin
                                n_out_valid  = 1'b1;
                                n_out_status = gbba_pkg::ST_NOFREE;
                            end else begin
                                n_state = S_GCHK;
                            end
                        end
                        gbba_pkg::MODE_INIT: begin
                            n_init  = 1'b1;
                            n_caddr = '0;
                            n_state = S_CLEAR;
                        end
                        default: begin
                            if (i_q.item.below) begin
                                n_out_valid  = 1'b1;
                                n_out_status = gbba_pkg::ST_RANGE;
                            end else begin
                                n_state = S_DDIV;
                            end
                        end
                    endcase
                end
            end
            // Allocate: walk groups in order
            S_GCHK: begin
                if (r_g >= ng_e) begin
                    n_out_valid  = 1'b1;
                    n_out_status = gbba_pkg::ST_NOFREE;
                    n_state      = S_IDLE;
                end else if (cur_cnt == '0) begin
                    n_g  = r_g + 4'd1;
                    n_lo = r_lo + {3'b0, bpg_e};
                end else begin
                    n_state = S_GSPAN;
                end
            end
            S_GSPAN: begin
                n_hi    = gbba_pkg::span_hi(r_lo, last, bpg_e, i_cfg.total_blocks,
                                            i_cfg.fdb);
                n_state = S_AREAD;
            end
            S_AREAD: begin
                if ({3'b0, r_hi} <= r_lo) begin
                    n_g     = r_g + 4'd1;
                    n_lo    = r_lo + {3'b0, bpg_e};
                    n_state = S_GCHK;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_lo[AW+4:5];
                    n_w       = r_lo[AW+4:5];
                    n_state   = S_ATEST;
                end
            end
            // One bitmap word per cycle, next word read ahead
            S_ATEST: begin
                if ({1'b0, r_w} >= r_hi[CW-1:5]) begin
                    vmask = (32'd1 << r_hi[4:0]) - 32'd1;
                end
                fbits = ~ram_rdata & vmask;
                for (int b = 31; b >= 0; b--) begin
                    if (fbits[b]) idx = 5'(b);
                end
                if (fbits != '0) begin
                    ram_we       = 1'b1;
                    ram_waddr    = r_w;
                    ram_wdata    = ram_rdata | (32'd1 << idx);
                    cnt_we       = 1'b1;
                    cnt_val      = dec_sat(cur_cnt);
                    n_total      = dec_sat(r_total);
                    n_out_valid  = 1'b1;
                    n_out_result = {r_w, idx} + {15'b0, i_cfg.fdb};
                    n_state      = S_IDLE;
                end else if ({({1'b0, r_w} + 12'd1), 5'b0} >= {1'b0, r_hi}) begin
                    n_g     = r_g + 4'd1;
                    n_lo    = r_lo + {3'b0, bpg_e};
                    n_state = S_GCHK;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_w + 1'b1;
                    n_w       = r_w + 1'b1;
                end
            end
            // Free / reserve: find the group by repeated subtraction
            S_DDIV: begin
                if ({1'b0, r_rem} >= bpg_e) begin
                    if (r_g + 4'd1 >= ng_e) begin
                        n_out_valid  = 1'b1;
                        n_out_status = gbba_pkg::ST_RANGE;
                        n_state      = S_IDLE;
                    end else begin
                        n_rem = r_rem - bpg_e[15:0];
                        n_g   = r_g + 4'd1;
                        n_lo  = r_lo + {3'b0, bpg_e};
                    end
                end else begin
                    n_state = S_DSPAN;
                end
            end
            S_DSPAN: begin
                n_hi    = gbba_pkg::span_hi(r_lo, last, bpg_e, i_cfg.total_blocks,
                                            i_cfg.fdb);
                n_state = S_DREAD;
            end
            S_DREAD: begin
                if ({1'b0, r_pos} < r_hi) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_pos[15:5];
                    n_state   = S_DMOD;
                end else begin
                    n_out_valid  = 1'b1;
                    n_out_status = gbba_pkg::ST_RANGE;
                    n_state      = S_IDLE;
                end
            end
            S_DMOD: begin
                ram_waddr = r_pos[15:5];
                if (r_mode == gbba_pkg::MODE_FREE) begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata & ~bmask;
                    cnt_we    = 1'b1;
                    cnt_val   = inc_sat(cur_cnt);
                    n_total   = inc_sat(r_total);
                end else if ((ram_rdata & bmask) == '0) begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata | bmask;
                    cnt_we    = 1'b1;
                    cnt_val   = dec_sat(cur_cnt);
                    n_total   = dec_sat(r_total);
                end
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            // Initialize: span then count, group by group
            S_ISPAN: begin
                if (!r_iacc) begin
                    n_hi   = gbba_pkg::span_hi(r_lo, last, bpg_e, i_cfg.total_blocks,
                                               i_cfg.fdb);
                    n_iacc = 1'b1;
                end else begin
                    n_iacc = 1'b0;
                    if (r_g < ng_e && {3'b0, r_hi} > r_lo) begin
                        c = r_hi - r_lo[CW-1:0];
                    end
                    cnt_we  = 1'b1;
                    cnt_val = c;
                    s       = r_sum + {3'b0, c};
                    n_sum   = s;
                    if (r_g == 4'(gbba_pkg::MAX_GROUPS - 1)) begin
                        n_total     = (s > {3'b0, gbba_pkg::COUNT_MAX}) ?
                                      gbba_pkg::COUNT_MAX : s[CW-1:0];
                        n_init      = 1'b0;
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        n_g  = r_g + 4'd1;
                        n_lo = r_lo + {3'b0, bpg_e};
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_caddr     <= '0;
            r_init      <= 1'b0;
            r_iacc      <= 1'b0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < gbba_pkg::MAX_GROUPS; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_caddr     <= n_caddr;
            r_init      <= n_init;
            r_iacc      <= n_iacc;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
            if (cnt_we) begin
                r_cnt[r_g[GW-1:0]] <= cnt_val;
            end
        end
    end

    // Working and result registers
    always_ff @(posedge i_clk) begin
        r_g          <= n_g;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_w          <= n_w;
        r_rem        <= n_rem;
        r_pos        <= n_pos;
        r_mode       <= n_mode;
        r_sum        <= n_sum;
        r_out_result <= n_out_result;
        r_out_status <= n_out_status;
        r_out_free   <= n_total;
    end

    assign o_stat.clearing = (r_state == S_CLEAR) && !r_init;
    assign o_done          = r_out_valid;
    assign o_result_block  = r_out_result;
    assign o_status        = r_out_status;
    assign o_free_blocks   = r_out_free;

    // Checks
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status != gbba_pkg::ST_OK |-> o_result_block == 16'd0)
        else $error("failed operation returned a block number");

    a_total_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= gbba_pkg::COUNT_MAX)
        else $error("total free count above limit");

    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> !o_pop)
        else $error("queue popped during bitmap clear");

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

endmodule
